FILE: sv/hsv_to_rgb_converter_defines.svh
// Assertion macros for the HSV to RGB converter.
// Depends on nothing; the asserting modules must have aclk and aresetn in scope.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define HSV_TO_RGB_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("hsv_to_rgb_converter: assertion failed");
// Checked at every edge, reset included.
`define HSV_TO_RGB_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("hsv_to_rgb_converter: assertion failed");
`else
`define HSV_TO_RGB_ASSERT(label, prop)
`define HSV_TO_RGB_ASSERT_RST(label, prop)
`endif

`endif

FILE: sv/hsvrgb_pkg.sv
// Shared types and constants of the HSV to RGB converter.
// Depends on nothing.
package hsvrgb_pkg;

    // Pipeline depth from the input register to the output register.
    localparam int NUM_STAGES = 6;

    localparam int unsigned HSV_HUE_FULL    = 360;
    localparam int unsigned HSV_SECTOR      = 60;
    localparam int unsigned HSV_PERCENT     = 100;

    // Reciprocal multipliers for exact floor division over the value ranges used.
    localparam int unsigned DIV360_SHIFT = 24;
    localparam int unsigned DIV360_MUL   = (1 << DIV360_SHIFT) / 360 + 1;
    localparam int unsigned DIV100_SHIFT = 22;
    localparam int unsigned DIV100_MUL   = (1 << DIV100_SHIFT) / 100 + 1;
    localparam int unsigned DIV60_SHIFT  = 20;
    localparam int unsigned DIV60_MUL    = (1 << DIV60_SHIFT) / 60 + 1;

    // Sixty-degree hue sectors.
    typedef enum logic [2:0] {
        SECT_RED_YELLOW    = 3'd0,
        SECT_YELLOW_GREEN  = 3'd1,
        SECT_GREEN_CYAN    = 3'd2,
        SECT_CYAN_BLUE     = 3'd3,
        SECT_BLUE_MAGENTA  = 3'd4,
        SECT_MAGENTA_RED   = 3'd5
    } hsvrgb_sector_t;

    typedef struct packed {
        logic [15:0] hue;
        logic [6:0]  saturation;
        logic [6:0]  brightness_value;
    } hsvrgb_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } hsvrgb_out_t;

    // Per-stage load enables and valid bits from the pipeline control.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] vld;
    } hsvrgb_ctrl_t;

endpackage

FILE: sv/hsvrgb_pipe_ctrl.sv
// Valid bits and stage load enables of the converter pipeline.
// Depends on hsvrgb_pkg and hsv_to_rgb_converter_defines.svh.
`include "hsv_to_rgb_converter_defines.svh"

module hsvrgb_pipe_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  logic                      m_ready,
    output hsvrgb_pkg::hsvrgb_ctrl_t  ctrl
);
    import hsvrgb_pkg::*;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] load;

    // A stage loads when it is empty or its request moves on this cycle.
    always_comb begin
        load[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            load[k] = !vld_reg[k] || load[k+1];
        end
    end

    // Valid bits move forward with the data of each loading stage.
    always_comb begin
        vld_next = vld_reg;
        if (load[0]) begin
            vld_next[0] = s_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (load[k]) begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready   = load[0];
    assign m_valid   = vld_reg[NUM_STAGES-1];
    assign ctrl.load = load;
    assign ctrl.vld  = vld_reg;

    // An accepted request always lands in the first stage.
    `HSV_TO_RGB_ASSERT(a_accept_enters, s_valid && s_ready |=> vld_reg[0])
    // A request held back by the stage after it is never dropped.
    `HSV_TO_RGB_ASSERT(a_mid_hold, vld_reg[2] && !load[3] |=> vld_reg[2])
    // A delivered result with nothing behind it is not shown again.
    `HSV_TO_RGB_ASSERT(a_no_repeat,
        m_valid && m_ready && !vld_reg[NUM_STAGES-2] |=> !m_valid)
    // Reset empties the whole pipeline.
    `HSV_TO_RGB_ASSERT_RST(a_reset_clears, !aresetn |=> vld_reg == '0)

endmodule

FILE: sv/hsvrgb_datapath.sv
// Six-stage arithmetic of the converter: hue split, channel max/min, ramp, mux.
// Depends on hsvrgb_pkg and hsv_to_rgb_converter_defines.svh.
`include "hsv_to_rgb_converter_defines.svh"

module hsvrgb_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  hsvrgb_pkg::hsvrgb_ctrl_t  ctrl,
    input  hsvrgb_pkg::hsvrgb_in_t    s_data,
    output hsvrgb_pkg::hsvrgb_out_t   m_data
);
    import hsvrgb_pkg::*;

    // Stage 0 registers.
    logic [15:0]    hue0_reg;
    logic [7:0]     quot0_reg;
    logic [6:0]     sat0_reg;
    logic [7:0]     top0_reg;
    // Stage 1 registers.
    logic [8:0]     hmod1_reg;
    logic [14:0]    lprod1_reg;
    logic [7:0]     top1_reg;
    // Stage 2 registers.
    logic [7:0]     low2_reg;
    logic [7:0]     top2_reg;
    hsvrgb_sector_t sect2_reg;
    logic [5:0]     rem2_reg;
    // Stage 3 registers.
    logic [13:0]    aprod3_reg;
    logic [7:0]     low3_reg;
    logic [7:0]     top3_reg;
    hsvrgb_sector_t sect3_reg;
    // Stage 4 registers.
    logic [7:0]     adj4_reg;
    logic [7:0]     low4_reg;
    logic [7:0]     top4_reg;
    hsvrgb_sector_t sect4_reg;
    // Stage 5: output register.
    hsvrgb_out_t    out_reg;
    hsvrgb_out_t    out_next;

    // Stage 0: clamp percentages, scale value to 0..255, estimate hue / 360.
    logic [6:0]  sat_c;
    logic [6:0]  val_c;
    logic [14:0] val_scaled;
    logic [30:0] top_mul;
    logic [31:0] hue_mul;

    always_comb begin
        sat_c = (s_data.saturation > 7'(HSV_PERCENT)) ? 7'(HSV_PERCENT) : s_data.saturation;
        val_c = (s_data.brightness_value > 7'(HSV_PERCENT))
              ? 7'(HSV_PERCENT) : s_data.brightness_value;
        val_scaled = 15'({val_c, 8'b0}) - 15'(val_c);
        top_mul    = 31'(val_scaled) * 31'(DIV100_MUL);
        hue_mul    = 32'(s_data.hue) * 32'(DIV360_MUL);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            hue0_reg  <= s_data.hue;
            quot0_reg <= hue_mul[DIV360_SHIFT +: 8];
            sat0_reg  <= sat_c;
            top0_reg  <= top_mul[DIV100_SHIFT +: 8];
        end
    end

    // Stage 1: hue modulo 360, and max times (100 - saturation).
    logic [15:0] hue_base;
    logic [6:0]  inv_sat;

    always_comb begin
        hue_base = 16'(quot0_reg) * 16'(HSV_HUE_FULL);
        inv_sat  = 7'(HSV_PERCENT) - sat0_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[1]) begin
            hmod1_reg  <= 9'(hue0_reg - hue_base);
            lprod1_reg <= 15'(top0_reg) * 15'(inv_sat);
            top1_reg   <= top0_reg;
        end
    end

    // Stage 2: channel minimum, and the hue sector with its remainder.
    logic [30:0]    low_mul;
    hsvrgb_sector_t sect_next;
    logic [8:0]     sect_base;

    always_comb begin
        low_mul = 31'(lprod1_reg) * 31'(DIV100_MUL);
        priority if (hmod1_reg >= 9'(5 * HSV_SECTOR)) begin
            sect_next = SECT_MAGENTA_RED;
            sect_base = 9'(5 * HSV_SECTOR);
        end else if (hmod1_reg >= 9'(4 * HSV_SECTOR)) begin
            sect_next = SECT_BLUE_MAGENTA;
            sect_base = 9'(4 * HSV_SECTOR);
        end else if (hmod1_reg >= 9'(3 * HSV_SECTOR)) begin
            sect_next = SECT_CYAN_BLUE;
            sect_base = 9'(3 * HSV_SECTOR);
        end else if (hmod1_reg >= 9'(2 * HSV_SECTOR)) begin
            sect_next = SECT_GREEN_CYAN;
            sect_base = 9'(2 * HSV_SECTOR);
        end else if (hmod1_reg >= 9'(HSV_SECTOR)) begin
            sect_next = SECT_YELLOW_GREEN;
            sect_base = 9'(HSV_SECTOR);
        end else begin
            sect_next = SECT_RED_YELLOW;
            sect_base = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[2]) begin
            low2_reg  <= low_mul[DIV100_SHIFT +: 8];
            top2_reg  <= top1_reg;
            sect2_reg <= sect_next;
            rem2_reg  <= 6'(hmod1_reg - sect_base);
        end
    end

    // Stage 3: channel span times the remainder within the sector.
    logic [7:0] span;

    assign span = top2_reg - low2_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load[3]) begin
            aprod3_reg <= 14'(span) * 14'(rem2_reg);
            low3_reg   <= low2_reg;
            top3_reg   <= top2_reg;
            sect3_reg  <= sect2_reg;
        end
    end

    // Stage 4: ramp amount, the product divided by sixty.
    logic [28:0] adj_mul;

    assign adj_mul = 29'(aprod3_reg) * 29'(DIV60_MUL);

    always_ff @(posedge aclk) begin
        if (ctrl.load[4]) begin
            adj4_reg  <= adj_mul[DIV60_SHIFT +: 8];
            low4_reg  <= low3_reg;
            top4_reg  <= top3_reg;
            sect4_reg <= sect3_reg;
        end
    end

    // Stage 5: the sector picks max, min, rising or falling ramp per channel.
    logic [7:0] rise;
    logic [7:0] fall;

    always_comb begin
        rise = low4_reg + adj4_reg;
        fall = top4_reg - adj4_reg;
        unique case (sect4_reg)
            SECT_RED_YELLOW: begin
                out_next = '{red: top4_reg, green: rise, blue: low4_reg};
            end
            SECT_YELLOW_GREEN: begin
                out_next = '{red: fall, green: top4_reg, blue: low4_reg};
            end
            SECT_GREEN_CYAN: begin
                out_next = '{red: low4_reg, green: top4_reg, blue: rise};
            end
            SECT_CYAN_BLUE: begin
                out_next = '{red: low4_reg, green: fall, blue: top4_reg};
            end
            SECT_BLUE_MAGENTA: begin
                out_next = '{red: rise, green: low4_reg, blue: top4_reg};
            end
            default: begin
                out_next = '{red: top4_reg, green: low4_reg, blue: fall};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[5]) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

    // The reduced hue is always below a full turn.
    `HSV_TO_RGB_ASSERT(a_hue_reduced, ctrl.vld[1] |-> hmod1_reg < 9'(HSV_HUE_FULL))
    // Remainder stays inside the sector and the minimum never exceeds the maximum.
    `HSV_TO_RGB_ASSERT(a_sector_bounds,
        ctrl.vld[2] |-> rem2_reg < 6'(HSV_SECTOR) && low2_reg <= top2_reg)
    // The ramp never exceeds the channel span.
    `HSV_TO_RGB_ASSERT(a_ramp_bound,
        ctrl.vld[4] |-> adj4_reg <= top4_reg - low4_reg)
    // A result waiting at the output is held while the stage does not load.
    `HSV_TO_RGB_ASSERT(a_out_hold, ctrl.vld[5] && !ctrl.load[5] |=> $stable(out_reg))

endmodule

FILE: sv/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter.
// Depends on hsvrgb_pkg, hsvrgb_pipe_ctrl and hsvrgb_datapath.
//
// Usage:
// A request on the s_ channel carries hue in degrees (reduced modulo 360),
// saturation and value in percent (above 100 taken as 100). Each request
// gives exactly one result on the m_ channel: 8-bit red, green and blue.
// Both channels use valid/ready; a request moves when valid and ready are
// both high at a rising edge of aclk.
// A request accepted at a rising edge of aclk enters the first stage register
// and moves forward through the stage registers, the output register being the last of
// six pipeline stages set by the chain of reciprocal multiplies.
// Throughput is one request per cycle while m_ready stays high.
// When the receiver stalls, the result is held at the output and requests
// behind it close up into empty stages; s_ready falls only once every stage
// is full. aresetn (synchronous, active low) empties the pipeline.
module hsv_to_rgb_converter (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  hsvrgb_pkg::hsvrgb_in_t   s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output hsvrgb_pkg::hsvrgb_out_t  m_data
);
    import hsvrgb_pkg::*;

    hsvrgb_ctrl_t ctrl;

    // Stage valid bits and load enables.
    hsvrgb_pipe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctrl    (ctrl)
    );

    // Arithmetic stages and output register.
    hsvrgb_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule

FILE: tb/hsv_to_rgb_converter_test.sv
// Self-checking testbench for the HSV to RGB converter: every request is predicted
// in the bench and each result is compared field by field, in order.
// Depends on hsvrgb_pkg and hsv_to_rgb_converter.
module hsv_to_rgb_converter_test;

    import hsvrgb_pkg::*;

    localparam int unsigned CHANNEL_FULL = 255;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    hsvrgb_in_t  s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    hsvrgb_out_t m_data;

    // Colours still owed by the block, oldest first.
    hsvrgb_out_t expected_colours[$];
    int unsigned mismatch_count  = 0;
    int unsigned cycle_count     = 0;
    int unsigned sent_count      = 0;
    int unsigned received_count  = 0;
    bit          tx_gaps_on      = 1'b0;
    bit          rx_stalls_on    = 1'b0;
    int unsigned hold_off_cycles = 0;

    hsv_to_rgb_converter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Integer-sector conversion with floor division throughout.
    function automatic hsvrgb_out_t predict_colour(hsvrgb_in_t req);
        int unsigned    deg, sat, val, top, low, ramp, rise, fall;
        int unsigned    r, g, b;
        hsvrgb_sector_t sect;
        hsvrgb_out_t    rgb;
        deg  = req.hue % HSV_HUE_FULL;
        sat  = (req.saturation > HSV_PERCENT) ? HSV_PERCENT : req.saturation;
        val  = (req.brightness_value > HSV_PERCENT) ? HSV_PERCENT : req.brightness_value;
        top  = (val * CHANNEL_FULL) / HSV_PERCENT;
        low  = (top * (HSV_PERCENT - sat)) / HSV_PERCENT;
        sect = hsvrgb_sector_t'(deg / HSV_SECTOR);
        ramp = ((top - low) * (deg % HSV_SECTOR)) / HSV_SECTOR;
        rise = low + ramp;
        fall = top - ramp;
        case (sect)
            SECT_RED_YELLOW: begin
                r = top;  g = rise; b = low;
            end
            SECT_YELLOW_GREEN: begin
                r = fall; g = top;  b = low;
            end
            SECT_GREEN_CYAN: begin
                r = low;  g = top;  b = rise;
            end
            SECT_CYAN_BLUE: begin
                r = low;  g = fall; b = top;
            end
            SECT_BLUE_MAGENTA: begin
                r = rise; g = low;  b = top;
            end
            default: begin
                r = top;  g = low;  b = fall;
            end
        endcase
        rgb.red   = 8'(r);
        rgb.green = 8'(g);
        rgb.blue  = 8'(b);
        return rgb;
    endfunction

    // Percent fields are weighted towards zero, full scale and the saturating range.
    function automatic logic [6:0] random_percent();
        case ($urandom_range(0, 7))
            0:       return 7'd0;
            1:       return 7'd100;
            2:       return 7'($urandom_range(101, 127));
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic hsvrgb_in_t random_request();
        hsvrgb_in_t req;
        case ($urandom_range(0, 3))
            0:       req.hue = 16'($urandom_range(0, 359));
            1:       req.hue = 16'($urandom_range(0, 5) * HSV_SECTOR + $urandom_range(0, 1)
                               + 360 * $urandom_range(0, 181));
            default: req.hue = 16'($urandom);
        endcase
        req.saturation       = random_percent();
        req.brightness_value = random_percent();
        return req;
    endfunction

    // Offer one request and hold it until the block takes it; valid stays high afterwards.
    task automatic send_request(hsvrgb_in_t req);
        int unsigned gap;
        gap = tx_gaps_on ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    task automatic send_random(int unsigned count);
        repeat (count) send_request(random_request());
    endtask

    // Wait until every accepted request has produced its result.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (received_count != sent_count) @(posedge aclk);
    endtask

    // Extremes of every field, every sector edge, hue wrap, clamped and zero percents.
    task automatic test_directed_corners();
        hsvrgb_in_t req;
        int unsigned hues[16] = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300,
                                  359, 360, 719, 65535, 65400};
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        foreach (hues[i]) begin
            req.hue              = 16'(hues[i]);
            req.saturation       = (i % 2 == 0) ? 7'd100 : 7'd73;
            req.brightness_value = (i % 3 == 0) ? 7'd127 : 7'd100;
            send_request(req);
        end
        req = '{hue: 16'd200, saturation: 7'd0,   brightness_value: 7'd80};
        send_request(req);
        req = '{hue: 16'd45,  saturation: 7'd90,  brightness_value: 7'd0};
        send_request(req);
        req = '{hue: 16'd90,  saturation: 7'd127, brightness_value: 7'd127};
        send_request(req);
        req = '{hue: 16'd330, saturation: 7'd101, brightness_value: 7'd1};
        send_request(req);
        req = '{hue: 16'd0,   saturation: 7'd0,   brightness_value: 7'd0};
        send_request(req);
        req = '{hue: 16'hFFFF, saturation: 7'h7F, brightness_value: 7'd99};
        send_request(req);
        wait_for_drain();
    endtask

    // Back-to-back requests with the receiver always ready.
    task automatic test_full_rate_stream();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        send_random(150);
    endtask

    // Receiver holds off for a long stretch so the pipeline fills and stalls its input.
    task automatic test_backpressure_fill();
        tx_gaps_on      = 1'b0;
        rx_stalls_on    = 1'b0;
        send_random(1);
        hold_off_cycles = 80;
        send_random(40);
        wait_for_drain();
    endtask

    // Random gaps and stalls on both sides.
    task automatic test_random_idling();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        send_random(300);
    endtask

    // Stretches that switch idling on and off on either side.
    task automatic test_mixed_stretches();
        repeat (6) begin
            tx_gaps_on   = 1'($urandom_range(0, 1));
            rx_stalls_on = 1'($urandom_range(0, 1));
            send_random(25);
        end
        wait_for_drain();
    endtask

    // Result side: random or long stalls between results.
    always begin : result_receiver
        int unsigned pause;
        if (hold_off_cycles != 0) begin
            pause           = hold_off_cycles;
            hold_off_cycles = 0;
        end else begin
            pause = rx_stalls_on ? $urandom_range(0, 15) : 0;
        end
        if (pause != 0) begin
            m_ready <= 1'b0;
            repeat (pause) @(posedge aclk);
        end
        m_ready <= 1'b1;
        do @(posedge aclk); while (!(m_valid && m_ready));
    end

    task automatic check_channel(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each result with the oldest prediction, then record any new request.
    always @(posedge aclk) begin : colour_scoreboard
        hsvrgb_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                received_count++;
                if (expected_colours.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_data);
                    mismatch_count++;
                end else begin
                    want = expected_colours.pop_front();
                    check_channel("red",   want.red,   m_data.red);
                    check_channel("green", want.green, m_data.green);
                    check_channel("blue",  want.blue,  m_data.blue);
                end
            end
            if (s_valid && s_ready)
                expected_colours.push_back(predict_colour(s_data));
        end
    end

    // Watchdog against a hung pipeline.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_corners();
        test_full_rate_stream();
        test_backpressure_fill();
        test_random_idling();
        test_mixed_stretches();
        wait_for_drain();
        repeat (NUM_STAGES + 10) @(posedge aclk);
        if (mismatch_count == 0 && expected_colours.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
